@@ rtl/nrt_pkg.sv @@
package nrt_pkg;

  localparam int NEIGHBOR_SLOTS_DEF = 16;
  localparam int VIA_SLOTS_DEF      = 32;
  localparam logic [15:0] LIFETIME_RESET = 16'd60;

  typedef enum logic [1:0] {
    KIND_HEARD = 2'd0,
    KIND_VIA   = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NBR_FULL = 2'd1,
    STAT_VIA_FULL = 2'd2,
    STAT_IGNORED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VDROP,
    ST_NPACK
  } state_t;

  // Classified transaction as it travels from the front to the back.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] node;
    logic [7:0] target;
    logic [7:0] hops;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] next_hop;
    logic       found;
    status_t    status;
    logic [4:0] neighbor_count;
    logic [5:0] via_count;
  } result_t;

endpackage

@@ rtl/nrt_front.sv @@
module nrt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_node_id,
  input  logic [7:0]         in_target_id,
  input  logic [7:0]         in_reported_hops,
  output logic               q_valid,
  output nrt_pkg::item_t     q_item,
  input  logic               q_pop
);

  // Two-entry queue; slot 0 is the head.
  nrt_pkg::item_t q_r [2];
  nrt_pkg::item_t q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;
  nrt_pkg::item_t in_item;
  logic push;

  always_comb begin
    in_item.kind   = nrt_pkg::kind_t'(in_kind);
    in_item.node   = in_node_id;
    in_item.target = in_target_id;
    in_item.hops   = (in_reported_hops == 8'hFF) ? 8'hFF : in_reported_hops + 8'd1;
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[0];

  always_comb begin
    q_nxt[0] = q_r[0];
    q_nxt[1] = q_r[1];
    cnt_nxt  = cnt_r;
    if (q_pop && q_valid) begin
      q_nxt[0] = q_r[1];
      cnt_nxt  = cnt_nxt - 2'd1;
    end
    if (push) begin
      q_nxt[cnt_nxt[0]] = in_item;
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/nrt_back.sv @@
module nrt_back #(
  parameter int NEIGHBOR_SLOTS = nrt_pkg::NEIGHBOR_SLOTS_DEF,
  parameter int VIA_SLOTS      = nrt_pkg::VIA_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        lifetime,
  input  logic               q_valid,
  input  nrt_pkg::item_t     q_item,
  output logic               q_pop,
  output nrt_pkg::result_t   res
);

  localparam int NCW = $clog2(NEIGHBOR_SLOTS + 1);
  localparam int VCW = $clog2(VIA_SLOTS + 1);
  localparam int NIW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam int VIW = (VIA_SLOTS > 1) ? $clog2(VIA_SLOTS) : 1;

  logic [7:0]  nid_r   [NEIGHBOR_SLOTS];
  logic [15:0] ntim_r  [NEIGHBOR_SLOTS];
  logic [7:0]  vdest_r [VIA_SLOTS];
  logic [7:0]  vhops_r [VIA_SLOTS];
  logic [7:0]  vhost_r [VIA_SLOTS];

  nrt_pkg::state_t  state_r, state_nxt;
  nrt_pkg::item_t   item_r, item_nxt;
  logic [NCW-1:0]   ntot_r, ntot_nxt, nr_r, nr_nxt, nw_r, nw_nxt;
  logic [VCW-1:0]   vtot_r, vtot_nxt, vr_r, vr_nxt, vw_r, vw_nxt;
  logic             acc_r, acc_nxt;
  nrt_pkg::result_t res_r, res_nxt;

  logic             nwe;
  logic [NIW-1:0]   nwa;
  logic [7:0]       nwid;
  logic [15:0]      nwtim;
  logic             vwe;
  logic [VIW-1:0]   vwa;
  logic [7:0]       vwdest, vwhops, vwhost;

  // Lookups over the valid part of each table.
  logic [7:0]     nkey;
  logic           nhit;
  logic [NIW-1:0] nidx;
  logic           vhit;
  logic [VIW-1:0] vidx;

  assign nkey = (state_r == nrt_pkg::ST_VDROP) ? item_r.node : q_item.target;

  always_comb begin
    nhit = 1'b0;
    nidx = '0;
    for (int i = NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
      if (NCW'(i) < ntot_r && nid_r[i] == nkey) begin
        nhit = 1'b1;
        nidx = NIW'(i);
      end
    end
    vhit = 1'b0;
    vidx = '0;
    for (int i = VIA_SLOTS - 1; i >= 0; i--) begin
      if (VCW'(i) < vtot_r && vdest_r[i] == q_item.target) begin
        vhit = 1'b1;
        vidx = VIW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    ntot_nxt  = ntot_r;
    nr_nxt    = nr_r;
    nw_nxt    = nw_r;
    vtot_nxt  = vtot_r;
    vr_nxt    = vr_r;
    vw_nxt    = vw_r;
    acc_nxt   = acc_r;
    res_nxt   = '0;
    q_pop     = 1'b0;
    nwe = 1'b0; nwa = '0; nwid = '0; nwtim = '0;
    vwe = 1'b0; vwa = '0; vwdest = '0; vwhops = '0; vwhost = '0;
    unique case (state_r)
      nrt_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          unique case (q_item.kind)
            nrt_pkg::KIND_HEARD: begin
              state_nxt = nrt_pkg::ST_VDROP;
              vr_nxt = '0;
              vw_nxt = '0;
            end
            nrt_pkg::KIND_TICK: begin
              state_nxt = nrt_pkg::ST_NPACK;
              nr_nxt = '0;
              nw_nxt = '0;
            end
            nrt_pkg::KIND_VIA: begin
              res_nxt.valid  = 1'b1;
              res_nxt.status = nrt_pkg::STAT_OK;
              if (!acc_r) begin
                res_nxt.status = nrt_pkg::STAT_IGNORED;
              end else if (vhit) begin
                if (vhops_r[vidx] >= q_item.hops) begin
                  vwe = 1'b1; vwa = vidx;
                  vwdest = q_item.target; vwhops = q_item.hops; vwhost = q_item.node;
                end
              end else if (vtot_r >= VCW'(VIA_SLOTS)) begin
                res_nxt.status = nrt_pkg::STAT_VIA_FULL;
              end else begin
                vwe = 1'b1; vwa = vtot_r[VIW-1:0];
                vwdest = q_item.target; vwhops = q_item.hops; vwhost = q_item.node;
                vtot_nxt = vtot_r + VCW'(1);
              end
            end
            nrt_pkg::KIND_QUERY: begin
              res_nxt.valid = 1'b1;
              if (nhit) begin
                res_nxt.found    = 1'b1;
                res_nxt.next_hop = q_item.target;
              end else if (vhit) begin
                res_nxt.found    = 1'b1;
                res_nxt.next_hop = vhost_r[vidx];
              end
            end
            default: ;
          endcase
        end
      end
      nrt_pkg::ST_VDROP: begin
        if (vr_r < vtot_r) begin
          if (vhost_r[vr_r[VIW-1:0]] != item_r.node) begin
            vwe = 1'b1; vwa = vw_r[VIW-1:0];
            vwdest = vdest_r[vr_r[VIW-1:0]];
            vwhops = vhops_r[vr_r[VIW-1:0]];
            vwhost = vhost_r[vr_r[VIW-1:0]];
            vw_nxt = vw_r + VCW'(1);
          end
          vr_nxt = vr_r + VCW'(1);
        end else begin
          // Via sweep done: now refresh or add the neighbor, or report a full table.
          vtot_nxt       = vw_r;
          state_nxt      = nrt_pkg::ST_IDLE;
          res_nxt.valid  = 1'b1;
          res_nxt.status = nrt_pkg::STAT_OK;
          acc_nxt        = 1'b1;
          if (nhit) begin
            nwe = 1'b1; nwa = nidx; nwid = item_r.node; nwtim = lifetime;
          end else if (ntot_r >= NCW'(NEIGHBOR_SLOTS)) begin
            acc_nxt        = 1'b0;
            res_nxt.status = nrt_pkg::STAT_NBR_FULL;
          end else begin
            nwe = 1'b1; nwa = ntot_r[NIW-1:0]; nwid = item_r.node; nwtim = lifetime;
            ntot_nxt = ntot_r + NCW'(1);
          end
        end
      end
      nrt_pkg::ST_NPACK: begin
        if (nr_r < ntot_r) begin
          if (ntim_r[nr_r[NIW-1:0]] > 16'd1) begin
            nwe = 1'b1; nwa = nw_r[NIW-1:0];
            nwid  = nid_r[nr_r[NIW-1:0]];
            nwtim = ntim_r[nr_r[NIW-1:0]] - 16'd1;
            nw_nxt = nw_r + NCW'(1);
          end
          nr_nxt = nr_r + NCW'(1);
        end else begin
          ntot_nxt      = nw_r;
          state_nxt     = nrt_pkg::ST_IDLE;
          res_nxt.valid = 1'b1;
        end
      end
      default: state_nxt = nrt_pkg::ST_IDLE;
    endcase
    res_nxt.neighbor_count = 5'(ntot_nxt);
    res_nxt.via_count      = 6'(vtot_nxt);
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    nr_r   <= nr_nxt;
    nw_r   <= nw_nxt;
    vr_r   <= vr_nxt;
    vw_r   <= vw_nxt;
    if (nwe) begin
      nid_r[nwa]  <= nwid;
      ntim_r[nwa] <= nwtim;
    end
    if (vwe) begin
      vdest_r[vwa] <= vwdest;
      vhops_r[vwa] <= vwhops;
      vhost_r[vwa] <= vwhost;
    end
    if (!rst_n) begin
      state_r <= nrt_pkg::ST_IDLE;
      ntot_r  <= '0;
      vtot_r  <= '0;
      acc_r   <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ntot_r  <= ntot_nxt;
      vtot_r  <= vtot_nxt;
      acc_r   <= acc_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/neighbor_route_table.sv @@
// Neighbor and route table. A transaction is accepted when start is high
// and busy is low; its result appears on the out_ ports for exactly one
// cycle with out_valid high, and the receiver cannot stall it. A two-entry
// queue sits between the front, which takes transactions, and the back,
// which executes them one at a time. A via report or a route query is
// answered from the queue head and its result is registered; a neighbor
// heard event first has the back sweep the via table one entry per cycle
// to drop the vias of that host; a tick sweeps the neighbor table the same
// way to age it and drop expired neighbors. busy is high only while both
// queue entries are occupied. The lifetime register may be written only
// while the block is idle.
module neighbor_route_table #(
  parameter int NEIGHBOR_SLOTS = nrt_pkg::NEIGHBOR_SLOTS_DEF,
  parameter int VIA_SLOTS      = nrt_pkg::VIA_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_node_id,
  input  logic [7:0]  in_target_id,
  input  logic [7:0]  in_reported_hops,
  output logic        out_valid,
  output logic [7:0]  out_next_hop,
  output logic        out_found,
  output logic [1:0]  out_status,
  output logic [4:0]  out_neighbor_count,
  output logic [5:0]  out_via_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Lifetime loaded into a neighbor's timer each time it is heard.
  logic [15:0] lifetime_r;

  logic             q_valid;
  logic             q_pop;
  nrt_pkg::item_t   q_item;
  nrt_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= nrt_pkg::LIFETIME_RESET;
    end else if (cfg_we) begin
      lifetime_r <= cfg_wdata;
    end
  end

  nrt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_node_id       (in_node_id),
    .in_target_id     (in_target_id),
    .in_reported_hops (in_reported_hops),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  nrt_back #(
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS),
    .VIA_SLOTS      (VIA_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .lifetime (lifetime_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res      (res)
  );

  assign out_valid          = res.valid;
  assign out_next_hop       = res.next_hop;
  assign out_found          = res.found;
  assign out_status         = res.status;
  assign out_neighbor_count = res.neighbor_count;
  assign out_via_count      = res.via_count;

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;

  localparam int NBR_SLOTS = 16;
  localparam int VIA_SLOTS = 32;
  localparam int RANDOM_ITEMS = 1550;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [7:0]  in_node_id;
  logic [7:0]  in_target_id;
  logic [7:0]  in_reported_hops;
  logic        out_valid;
  logic [7:0]  out_next_hop;
  logic        out_found;
  logic [1:0]  out_status;
  logic [4:0]  out_neighbor_count;
  logic [5:0]  out_via_count;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  neighbor_route_table DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_node_id(in_node_id), .in_target_id(in_target_id),
    .in_reported_hops(in_reported_hops),
    .out_valid(out_valid), .out_next_hop(out_next_hop), .out_found(out_found),
    .out_status(out_status), .out_neighbor_count(out_neighbor_count),
    .out_via_count(out_via_count),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // One route-table answer as it appears on the out_ ports.
  typedef struct {
    logic [7:0]        next_hop;
    logic              found;
    nrt_pkg::status_t  status;
    logic [4:0]        nbr_count;
    logic [5:0]        via_count;
  } answer_t;

  // Shadow copy of the table contents, updated as each transaction is accepted.
  logic [15:0] lifetime;
  logic [7:0]  nbr_id [NBR_SLOTS];
  logic [15:0] nbr_timer [NBR_SLOTS];
  int          nbr_total;
  logic [7:0]  via_dest [VIA_SLOTS];
  logic [7:0]  via_hops [VIA_SLOTS];
  logic [7:0]  via_host [VIA_SLOTS];
  int          via_total;
  logic        host_accepted;

  answer_t pending_answers[$];
  int      mismatches;
  longint  cycles;
  int      sender_idle_pct;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: if the run does not finish by the limit, something hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("neighbor_route_table regression: fail");
      $finish;
    end
  end

  function automatic void table_reset();
    lifetime = nrt_pkg::LIFETIME_RESET;
    nbr_total = 0;
    via_total = 0;
    host_accepted = 1'b0;
  endfunction

  // Computes the answer for one transaction and applies its effect on the
  // shadow tables.
  function automatic answer_t route_table_step(nrt_pkg::kind_t kind, logic [7:0] node,
                                               logic [7:0] target,
                                               logic [7:0] reported);
    answer_t a;
    int w;
    int hit;
    logic [7:0] hops;
    a.next_hop = 8'd0;
    a.found = 1'b0;
    a.status = nrt_pkg::STAT_OK;
    hit = -1;
    case (kind)
      nrt_pkg::KIND_HEARD: begin
        // Every via of the heard node is dropped before the refresh.
        w = 0;
        for (int r = 0; r < via_total; r++) begin
          if (via_host[r] != node) begin
            via_dest[w] = via_dest[r];
            via_hops[w] = via_hops[r];
            via_host[w] = via_host[r];
            w++;
          end
        end
        via_total = w;
        for (int i = 0; i < nbr_total; i++)
          if (hit < 0 && nbr_id[i] == node) hit = i;
        if (hit >= 0) begin
          nbr_timer[hit] = lifetime;
          host_accepted = 1'b1;
        end else if (nbr_total >= NBR_SLOTS) begin
          host_accepted = 1'b0;
          a.status = nrt_pkg::STAT_NBR_FULL;
        end else begin
          nbr_id[nbr_total] = node;
          nbr_timer[nbr_total] = lifetime;
          nbr_total++;
          host_accepted = 1'b1;
        end
      end
      nrt_pkg::KIND_VIA: begin
        if (!host_accepted) begin
          a.status = nrt_pkg::STAT_IGNORED;
        end else begin
          hops = (reported == 8'hFF) ? 8'hFF : reported + 8'd1;
          for (int i = 0; i < via_total; i++)
            if (hit < 0 && via_dest[i] == target) hit = i;
          if (hit >= 0) begin
            // An equal hop count also takes over the host.
            if (via_hops[hit] >= hops) begin
              via_hops[hit] = hops;
              via_host[hit] = node;
            end
          end else if (via_total >= VIA_SLOTS) begin
            a.status = nrt_pkg::STAT_VIA_FULL;
          end else begin
            via_dest[via_total] = target;
            via_hops[via_total] = hops;
            via_host[via_total] = node;
            via_total++;
          end
        end
      end
      nrt_pkg::KIND_TICK: begin
        w = 0;
        for (int r = 0; r < nbr_total; r++) begin
          if (nbr_timer[r] > 16'd1) begin
            nbr_id[w] = nbr_id[r];
            nbr_timer[w] = nbr_timer[r] - 16'd1;
            w++;
          end
        end
        nbr_total = w;
      end
      default: begin
        for (int i = 0; i < nbr_total; i++)
          if (!a.found && nbr_id[i] == target) begin
            a.found = 1'b1;
            a.next_hop = target;
          end
        for (int i = 0; i < via_total; i++)
          if (!a.found && via_dest[i] == target) begin
            a.found = 1'b1;
            a.next_hop = via_host[i];
          end
      end
    endcase
    a.nbr_count = nbr_total[4:0];
    a.via_count = via_total[5:0];
    return a;
  endfunction

  // Drives one transaction and holds it until accepted. Busy is sampled in
  // the middle of the cycle, so it is the value seen by the next rising edge.
  // The shadow tables are updated at acceptance, so the queue stays in
  // acceptance order.
  task automatic send_item(nrt_pkg::kind_t kind, logic [7:0] node, logic [7:0] target,
                           logic [7:0] reported);
    answer_t a;
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_node_id <= node;
    in_target_id <= target;
    in_reported_hops <= reported;
    forever begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
      if (taken) break;
    end
    a = route_table_step(kind, node, target, reported);
    pending_answers.push_back(a);
  endtask

  // Waits for every answer, then lets the back finish its longest sweep
  // before the lifetime register may be touched.
  task automatic drain();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (VIA_SLOTS + NBR_SLOTS + 8) @(posedge clk);
  endtask

  task automatic write_lifetime(logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lifetime = value;
  endtask

  // Results cannot be held off, so every strobe is checked on the spot.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: next_hop %0d found %0d status %0d",
                   out_next_hop, out_found, out_status);
      end else begin
        e = pending_answers.pop_front();
        if (out_next_hop !== e.next_hop || out_found !== e.found ||
            out_status !== e.status || out_neighbor_count !== e.nbr_count ||
            out_via_count !== e.via_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hop %0d fnd %0d st %0d nc %0d vc %0d, got %0d %0d %0d %0d %0d",
                     e.next_hop, e.found, e.status, e.nbr_count, e.via_count,
                     out_next_hop, out_found, out_status, out_neighbor_count,
                     out_via_count);
        end
      end
    end
  end

  // Directed rows: kind, node, target, hops, and whether the answer is typed
  // in (check_fixed) alongside the predictor.
  typedef struct {
    nrt_pkg::kind_t   kind;
    logic [7:0]       node;
    logic [7:0]       target;
    logic [7:0]       hops;
    logic             check_fixed;
    logic [7:0]       next_hop;
    logic             found;
    nrt_pkg::status_t status;
  } row_t;

  row_t directed [20];

  task automatic run_directed();
    answer_t a;
    foreach (directed[i]) begin
      send_item(directed[i].kind, directed[i].node, directed[i].target,
                directed[i].hops);
      a = pending_answers[$];
      if (directed[i].check_fixed && (a.next_hop !== directed[i].next_hop ||
          a.found !== directed[i].found || a.status !== directed[i].status)) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d disagrees with table", i);
      end
    end
  endtask

  // Random traffic: mostly heard events followed by via reports from the
  // same host, so reports get past the acceptance flag; node ids come from
  // small pools unless wide_ids is set, so the tables fill and entries collide.
  task automatic run_random(int count, bit wide_ids);
    logic [7:0] host;
    int pick;
    int n;
    n = 0;
    while (n < count) begin
      host = wide_ids ? 8'($urandom_range(255)) : 8'($urandom_range(23));
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_item(nrt_pkg::KIND_HEARD, host, 8'($urandom), 8'($urandom));
        n++;
        repeat ($urandom_range(4)) begin
          send_item(nrt_pkg::KIND_VIA, host,
                    wide_ids ? 8'($urandom) : 8'($urandom_range(47)),
                    ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(20)));
          n++;
        end
      end else if (pick < 55) begin
        send_item(nrt_pkg::KIND_VIA, host, 8'($urandom), 8'($urandom));
        n++;
      end else if (pick < 70) begin
        send_item(nrt_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
        n++;
      end else begin
        send_item(nrt_pkg::KIND_QUERY, 8'($urandom),
                  ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(47)),
                  8'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    cycles = 0;
    mismatches = 0;
    sender_idle_pct = 16;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_kind <= nrt_pkg::KIND_HEARD;
    in_node_id <= 8'd0;
    in_target_id <= 8'd0;
    in_reported_hops <= 8'd0;
    cfg_we <= 1'b0;
    cfg_wdata <= 16'd0;
    table_reset();
    directed = '{
      '{nrt_pkg::KIND_VIA,   8'd5,   8'd9,   8'd3,   1'b1, 8'd0,   1'b0, nrt_pkg::STAT_IGNORED},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_HEARD, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_HEARD, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_VIA,   8'd255, 8'd200, 8'd255, 1'b1, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_VIA,   8'd255, 8'd201, 8'd254, 1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_HEARD, 8'd170, 8'd0,   8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_VIA,   8'd170, 8'd200, 8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd200, 8'd0,   1'b1, 8'd170, 1'b1, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_HEARD, 8'd85,  8'd0,   8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_VIA,   8'd85,  8'd200, 8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd200, 8'd0,   1'b1, 8'd85,  1'b1, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_VIA,   8'd85,  8'd0,   8'd7,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   1'b1, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd255, 8'd0,   1'b1, 8'd255, 1'b1, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_HEARD, 8'd85,  8'd0,   8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd201, 8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_TICK,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_QUERY, 8'd0,   8'd77,  8'd0,   1'b1, 8'd0,   1'b0, nrt_pkg::STAT_OK},
      '{nrt_pkg::KIND_TICK,  8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   1'b0, nrt_pkg::STAT_OK}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    // Fill the neighbor table past capacity, then send a report from the
    // rejected node, which must be ignored.
    for (int i = 0; i < NBR_SLOTS + 2; i++)
      send_item(nrt_pkg::KIND_HEARD, 8'(i + 100), 8'd0, 8'd0);
    send_item(nrt_pkg::KIND_VIA, 8'd117, 8'd3, 8'd1);
    // Fill the via table past capacity from one accepted host.
    send_item(nrt_pkg::KIND_HEARD, 8'd100, 8'd0, 8'd0);
    for (int i = 0; i < VIA_SLOTS + 2; i++)
      send_item(nrt_pkg::KIND_VIA, 8'd100, 8'(i + 1), 8'(i));
    drain();

    // Zero lifetime expires at the next tick just like a lifetime of one.
    write_lifetime(16'd0);
    send_item(nrt_pkg::KIND_HEARD, 8'd100, 8'd0, 8'd0);
    send_item(nrt_pkg::KIND_HEARD, 8'd42, 8'd0, 8'd0);
    send_item(nrt_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0);
    drain();
    write_lifetime(16'd1);
    send_item(nrt_pkg::KIND_HEARD, 8'd9, 8'd0, 8'd0);
    send_item(nrt_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0);
    drain();

    // Random phases: sender idling lightly, then heavily, then not at all; several lifetimes.
    write_lifetime(16'd3);
    run_random(RANDOM_ITEMS / 4, 1'b0);
    drain();
    write_lifetime(16'hFFFF);
    run_random(RANDOM_ITEMS / 4, 1'b1);
    drain();
    sender_idle_pct = 70;
    write_lifetime(16'd1);
    run_random(RANDOM_ITEMS / 8, 1'b0);
    drain();
    write_lifetime(16'($urandom_range(2, 12)));
    run_random(RANDOM_ITEMS / 8, 1'b0);
    drain();
    sender_idle_pct = 0;
    write_lifetime(16'(16'h5555 ^ 16'($urandom)));
    run_random(RANDOM_ITEMS / 8, 1'b1);
    drain();
    write_lifetime(16'd6);
    run_random(RANDOM_ITEMS / 8, 1'b0);
    drain();

    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("neighbor_route_table regression: pass");
    end else begin
      $display("neighbor_route_table regression: fail");
    end
    $finish;
  end

endmodule
